// ----- hw/rtl/bem_pkg.sv -----
// Byte entropy meter: shared widths, item types, controller states and
// datapath command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bem_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int SUM_W   = COUNT_WIDTH + 8;
    localparam int EXP_W   = $clog2(SUM_W);
    localparam int LOG_W   = EXP_W + FRAC_BITS;
    localparam int PROD_W  = COUNT_WIDTH + LOG_W;
    localparam int QSUM_W  = LOG_W + 8;
    localparam int DIV_W   = QSUM_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int LB_W    = 16 + FRAC_BITS - 8;
    localparam int ENT_W   = 24;
    localparam int DIST_W  = 9;
    localparam int TOT_W   = 32;

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic REG_COUNT_NP  = 1'b0;
    localparam logic REG_LOG_BASE  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [ENT_W-1:0]  entropy_q;
        logic [DIST_W-1:0] distinct_count;
        logic [TOT_W-1:0]  total_count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DRAIN, S_START, S_LOGT, S_RD, S_CHKBIN, S_LOGC, S_MUL,
        S_DIVB, S_BASE, S_LOGB, S_CHKB, S_DIVH, S_ZERO, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        LOG_SRC_SUM, LOG_SRC_BIN, LOG_SRC_DIST
    } t_log_src;

    typedef enum logic [1:0] {
        ENT_ZERO, ENT_H2, ENT_DIV
    } t_ent_src;

    typedef struct packed {
        logic     walk_init;
        logic     log_start;
        t_log_src log_src;
        logic     save_lt;
        logic     rd_bin;
        logic     bin_next;
        logic     mul;
        logic     div_bin;
        logic     div_h;
        logic     acc;
        logic     lb_load;
        logic     ent_load;
        t_ent_src ent_src;
        logic     clear_hist;
    } t_dp_cmd;

    typedef struct packed {
        logic log_done;
        logic div_done;
        logic sum_zero;
        logic bin_valid;
        logic bin_last;
        logic base_zero;
        logic lb_zero;
        logic lb_unit;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- hw/rtl/bem_log2.sv -----
// Fixed-point log2 unit: bit-serial normalize, then one squaring per fraction bit.
// Depends on bem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bem_log2
    import bem_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_n,
    output logic                  o_done,
    output logic [LOG_W-1:0]      o_res
);
    localparam int XN    = SUM_W + 32;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_norm;
    logic                 r_sqr;
    logic                 r_done;
    logic [XN-1:0]        r_x;
    logic [EXP_W-1:0]     r_e;
    logic [31:0]          r_m;
    logic [FRAC_BITS-1:0] r_frac;
    logic [CNT_W-1:0]     r_cnt;
    logic [63:0]          w_sq;
    logic [32:0]          w_mm;

    assign w_sq = 64'(r_m) * 64'(r_m);
    assign w_mm = w_sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 1'b0;
            r_sqr  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_norm <= 1'b1;
            end else if (r_norm && r_x[XN-1]) begin
                r_norm <= 1'b0;
                r_sqr  <= 1'b1;
            end else if (r_sqr && r_cnt == CNT_W'(1)) begin
                r_sqr  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= {i_n, 32'b0};
            r_e <= EXP_W'(SUM_W - 1);
        end else if (r_norm) begin
            if (r_x[XN-1]) begin
                r_m    <= r_x[XN-1 -: 32];
                r_cnt  <= CNT_W'(FRAC_BITS);
                r_frac <= '0;
            end else begin
                r_x <= {r_x[XN-2:0], 1'b0};
                r_e <= r_e - 1'b1;
            end
        end else if (r_sqr) begin
            r_m    <= w_mm[32] ? w_mm[32:1] : w_mm[31:0];
            r_frac <= {r_frac[FRAC_BITS-2:0], w_mm[32]};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_res  = {r_e, r_frac};
endmodule
`default_nettype wire

// ----- hw/rtl/bem_div.sv -----
// Restoring divider, one quotient bit per cycle, with a preset partial remainder.
// Depends on bem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bem_div
    import bem_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_den,
    input  wire logic [SUM_W-1:0]  i_rem0,
    input  wire logic [DIV_W-1:0]  i_bits,
    input  wire logic [DCNT_W-1:0] i_steps,
    output logic                   o_done,
    output logic [DIV_W-1:0]       o_quo,
    output logic [SUM_W-1:0]       o_rem
);
    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_den;
    logic [SUM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_bits;
    logic [DIV_W-1:0]  r_quo;
    logic [SUM_W:0]    w_x;
    logic              w_ge;
    logic [SUM_W:0]    w_diff;

    assign w_x    = {r_rem, r_bits[DIV_W-1]};
    assign w_ge   = w_x >= {1'b0, r_den};
    assign w_diff = w_x - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= i_rem0;
            r_bits <= i_bits;
            r_cnt  <= i_steps;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[SUM_W-1:0] : w_x[SUM_W-1:0];
            r_bits <= {r_bits[DIV_W-2:0], 1'b0};
            r_quo  <= {r_quo[DIV_W-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ----- hw/rtl/bem_datapath.sv -----
// Datapath: histogram memory with forwarded read-modify-write, totals,
// entropy accumulators. Uses bem_log2 and bem_div; depends on bem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bem_datapath
    import bem_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_count_en,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_user_base,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    output t_out_item        o_result
);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [LB_W-1:0]        LB_ONE  = LB_W'(1) << FRAC_BITS;
    localparam logic [ENT_W-1:0]       ENT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_mem [256];
    logic [255:0]           r_vld;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [COUNT_WIDTH-1:0] r_fwd_data;
    logic                   r_fwd;
    logic                   r_rd_vld;
    logic                   r_s1_valid;
    logic [7:0]             r_s1_addr;
    logic [TOT_W-1:0]       r_total;
    logic [DIST_W-1:0]      r_distinct;
    logic [SUM_W-1:0]       r_sum;
    logic [7:0]             r_k;
    logic [LOG_W-1:0]       r_lt;
    logic [COUNT_WIDTH-1:0] r_c;
    logic [PROD_W-1:0]      r_prod;
    logic [QSUM_W-1:0]      r_q;
    logic [SUM_W-1:0]       r_rsum;
    logic [LB_W-1:0]        r_lb;
    logic [ENT_W-1:0]       r_ent;

    logic [7:0]             w_raddr;
    logic                   w_hit;
    logic [COUNT_WIDTH-1:0] w_cur_cnt;
    logic                   w_cnt_sat;
    logic [COUNT_WIDTH-1:0] w_new_cnt;
    logic [SUM_W-1:0]       w_log_n;
    logic                   w_log_done;
    logic [LOG_W-1:0]       w_log_res;
    logic [LOG_W-1:0]       w_d;
    logic                   w_div_start;
    logic [SUM_W-1:0]       w_div_den;
    logic [SUM_W-1:0]       w_div_rem0;
    logic [DIV_W-1:0]       w_div_bits;
    logic [DCNT_W-1:0]      w_div_steps;
    logic                   w_div_done;
    logic [DIV_W-1:0]       w_div_quo;
    logic [SUM_W-1:0]       w_div_rem;
    logic [SUM_W:0]         w_rs;
    logic                   w_rs_ge;
    logic [SUM_W:0]         w_rs_sub;

    function automatic logic [ENT_W-1:0] sat_ent(input logic [DIV_W-1:0] v);
        return (v > DIV_W'(ENT_MAX)) ? ENT_MAX : v[ENT_W-1:0];
    endfunction

    assign w_raddr   = i_cmd.rd_bin ? r_k : i_byte;
    assign w_hit     = r_s1_valid && (r_s1_addr == w_raddr);
    assign w_cur_cnt = r_fwd ? r_fwd_data : r_rdata;
    assign w_cnt_sat = w_cur_cnt == CNT_MAX;
    assign w_new_cnt = !r_rd_vld ? COUNT_WIDTH'(1)
                     : (w_cnt_sat ? w_cur_cnt : w_cur_cnt + 1'b1);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= w_new_cnt;
        end
        r_rdata    <= r_mem[w_raddr];
        r_fwd_data <= w_new_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_total    <= '0;
            r_distinct <= '0;
            r_sum      <= '0;
        end else begin
            r_s1_valid <= i_count_en;
            r_fwd      <= w_hit;
            r_rd_vld   <= r_vld[w_raddr] | w_hit;
            if (i_cmd.clear_hist) begin
                r_vld      <= '0;
                r_total    <= '0;
                r_distinct <= '0;
                r_sum      <= '0;
            end else if (r_s1_valid) begin
                r_vld[r_s1_addr] <= 1'b1;
                if (!r_rd_vld) begin
                    r_distinct <= r_distinct + 1'b1;
                end
                if (!r_rd_vld || !w_cnt_sat) begin
                    r_sum <= r_sum + 1'b1;
                end
                if (r_total != '1) begin
                    r_total <= r_total + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_count_en) begin
            r_s1_addr <= i_byte;
        end
    end

    always_comb begin
        case (i_cmd.log_src)
            LOG_SRC_SUM:  w_log_n = r_sum;
            LOG_SRC_BIN:  w_log_n = SUM_W'(w_cur_cnt);
            LOG_SRC_DIST: w_log_n = SUM_W'(r_distinct);
            default:      w_log_n = r_sum;
        endcase
    end

    bem_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_n     (w_log_n),
        .o_done  (w_log_done),
        .o_res   (w_log_res)
    );

    assign w_d = (r_lt > w_log_res) ? r_lt - w_log_res : '0;

    assign w_div_start = i_cmd.div_bin | i_cmd.div_h;
    assign w_div_den   = i_cmd.div_h ? SUM_W'(r_lb) : r_sum;
    assign w_div_rem0  = i_cmd.div_h ? '0 : SUM_W'(r_prod[PROD_W-1:LOG_W]);
    assign w_div_bits  = i_cmd.div_h ? {r_q, {FRAC_BITS{1'b0}}}
                                     : {r_prod[LOG_W-1:0], {(DIV_W-LOG_W){1'b0}}};
    assign w_div_steps = i_cmd.div_h ? DCNT_W'(DIV_W) : DCNT_W'(LOG_W);

    bem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_div_den),
        .i_rem0  (w_div_rem0),
        .i_bits  (w_div_bits),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    assign w_rs     = {1'b0, r_rsum} + {1'b0, w_div_rem};
    assign w_rs_ge  = w_rs >= {1'b0, r_sum};
    assign w_rs_sub = w_rs - {1'b0, r_sum};

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_k    <= '0;
            r_q    <= '0;
            r_rsum <= '0;
        end else begin
            if (i_cmd.bin_next) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.acc) begin
                r_q    <= r_q + QSUM_W'(w_div_quo[LOG_W-1:0]) + QSUM_W'(w_rs_ge);
                r_rsum <= w_rs_ge ? w_rs_sub[SUM_W-1:0] : w_rs[SUM_W-1:0];
            end
        end
        if (i_cmd.save_lt) begin
            r_lt <= w_log_res;
        end
        if (i_cmd.log_start && i_cmd.log_src == LOG_SRC_BIN) begin
            r_c <= w_cur_cnt;
        end
        if (i_cmd.mul) begin
            r_prod <= r_c * w_d;
        end
        if (i_cmd.lb_load) begin
            r_lb <= (i_user_base != '0) ? (LB_W'(i_user_base) << (FRAC_BITS - 8))
                                        : LB_W'(w_log_res);
        end
        if (i_cmd.ent_load) begin
            case (i_cmd.ent_src)
                ENT_ZERO: r_ent <= '0;
                ENT_H2:   r_ent <= sat_ent(DIV_W'(r_q));
                ENT_DIV:  r_ent <= sat_ent(w_div_quo);
                default:  r_ent <= '0;
            endcase
        end
    end

    assign o_stat.log_done  = w_log_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sum_zero  = r_sum == '0;
    assign o_stat.bin_valid = r_rd_vld;
    assign o_stat.bin_last  = r_k == 8'hFF;
    assign o_stat.base_zero = i_user_base == '0;
    assign o_stat.lb_zero   = r_lb == '0;
    assign o_stat.lb_unit   = r_lb == LB_ONE;

    assign o_result.entropy_q      = r_ent;
    assign o_result.distinct_count = r_distinct;
    assign o_result.total_count    = r_total;
endmodule
`default_nettype wire

// ----- hw/rtl/bem_ctrl.sv -----
// Controller: sequences the finish walk over the 256 bins and the base division.
// Depends on bem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bem_ctrl
    import bem_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fin_acc,
    input  wire logic     i_out_free,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_ready,
    output logic          o_out_load
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_fin_acc) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_START;
            S_START:  n_state = i_stat.sum_zero ? S_ZERO : S_LOGT;
            S_LOGT:   if (i_stat.log_done) n_state = S_RD;
            S_RD:     n_state = S_CHKBIN;
            S_CHKBIN: begin
                if (i_stat.bin_valid) n_state = S_LOGC;
                else if (i_stat.bin_last) n_state = S_BASE;
                else n_state = S_RD;
            end
            S_LOGC:   if (i_stat.log_done) n_state = S_MUL;
            S_MUL:    n_state = S_DIVB;
            S_DIVB:   if (i_stat.div_done) n_state = i_stat.bin_last ? S_BASE : S_RD;
            S_BASE:   n_state = i_stat.base_zero ? S_LOGB : S_CHKB;
            S_LOGB:   if (i_stat.log_done) n_state = S_CHKB;
            S_CHKB: begin
                if (i_stat.lb_zero || i_stat.lb_unit) n_state = S_OUT;
                else n_state = S_DIVH;
            end
            S_DIVH:   if (i_stat.div_done) n_state = S_OUT;
            S_ZERO:   n_state = S_OUT;
            S_OUT:    if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_START: begin
                o_cmd.walk_init = 1'b1;
                o_cmd.log_src   = LOG_SRC_SUM;
                o_cmd.log_start = !i_stat.sum_zero;
            end
            S_LOGT:   o_cmd.save_lt = i_stat.log_done;
            S_RD:     o_cmd.rd_bin = 1'b1;
            S_CHKBIN: begin
                o_cmd.log_src   = LOG_SRC_BIN;
                o_cmd.log_start = i_stat.bin_valid;
                o_cmd.bin_next  = !i_stat.bin_valid && !i_stat.bin_last;
            end
            S_LOGC:   o_cmd.mul = i_stat.log_done;
            S_MUL:    o_cmd.div_bin = 1'b1;
            S_DIVB: begin
                o_cmd.acc      = i_stat.div_done;
                o_cmd.bin_next = i_stat.div_done && !i_stat.bin_last;
            end
            S_BASE: begin
                o_cmd.log_src   = LOG_SRC_DIST;
                o_cmd.log_start = i_stat.base_zero;
                o_cmd.lb_load   = !i_stat.base_zero;
            end
            S_LOGB: begin
                o_cmd.log_src = LOG_SRC_DIST;
                o_cmd.lb_load = i_stat.log_done;
            end
            S_CHKB: begin
                o_cmd.div_h    = !i_stat.lb_zero && !i_stat.lb_unit;
                o_cmd.ent_load = i_stat.lb_zero || i_stat.lb_unit;
                o_cmd.ent_src  = i_stat.lb_zero ? ENT_ZERO : ENT_H2;
            end
            S_DIVH: begin
                o_cmd.ent_load = i_stat.div_done;
                o_cmd.ent_src  = ENT_DIV;
            end
            S_ZERO: begin
                o_cmd.ent_load = 1'b1;
                o_cmd.ent_src  = ENT_ZERO;
            end
            S_OUT: begin
                o_out_load       = i_out_free;
                o_cmd.clear_hist = i_out_free;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/byte_entropy_meter.sv -----
// Byte entropy meter: a data byte item is taken at one per cycle while idle and,
// if printable or count_np is set, counted into a 256-bin histogram with
// forwarded read-modify-write (one read, one write memory port). A finish item
// walks all 256 bins, reading and checking each; each counted bin passes the
// log2 unit (normalize, then squaring) and the serial divider, then the base
// division follows; no item is taken until the output register is loaded.
// Depends on bem_pkg, bem_ctrl, bem_datapath.
`timescale 1ns / 1ps
`default_nettype none
module byte_entropy_meter
    import bem_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic        r_count_np;
    logic [15:0] r_user_base;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        w_in_acc;
    logic        w_printable;
    logic        w_count_en;
    logic        w_fin_acc;
    logic        w_out_free;
    logic        w_out_load;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    t_out_item   w_result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_np  <= 1'b0;
            r_user_base <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_COUNT_NP: r_count_np  <= pwdata[0];
                REG_LOG_BASE: r_user_base <= pwdata[15:0];
                default:      r_count_np  <= r_count_np;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_COUNT_NP: prdata = {31'b0, r_count_np};
            REG_LOG_BASE: prdata = {16'b0, r_user_base};
            default:      prdata = '0;
        endcase
    end

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_printable = i_in_data.data_byte inside {[8'h20:8'h7E]};
    assign w_count_en  = w_in_acc && (i_in_data.op == OP_COUNT)
                         && (r_count_np || w_printable);
    assign w_fin_acc   = w_in_acc && (i_in_data.op == OP_FINISH);
    assign w_out_free  = !r_out_valid || i_out_ready;

    bem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin_acc  (w_fin_acc),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready),
        .o_out_load (w_out_load)
    );

    bem_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count_en  (w_count_en),
        .i_byte      (i_in_data.data_byte),
        .i_user_base (r_user_base),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

// ----- dv/byte_entropy_meter_tb.sv -----
// Testbench for byte_entropy_meter: drives byte and finish items, writes the
// config registers over APB, and checks each result against a fixed-point predictor.
// Depends on bem_pkg and the byte_entropy_meter RTL.
`timescale 1ns / 1ps
module byte_entropy_meter_tb;
    import bem_pkg::*;

    localparam logic [2:0] ADDR_COUNT_NP = 3'd0;
    localparam logic [2:0] ADDR_LOG_BASE = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    byte_entropy_meter dut (.*);

    // predictor state
    longint unsigned hist[256];
    int unsigned     byte_cnt;
    int unsigned     distinct_cnt;
    bit              cfg_count_np;
    bit [15:0]       cfg_log_base;

    t_out_item   expected_results[$];
    int          err_cnt;
    bit          out_stall_on;
    int          out_wait;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint unsigned log2_fix(longint unsigned n);
        int unsigned     e;
        longint unsigned m;
        longint unsigned res;
        e = 0;
        if (n == 0) return 0;
        while (e < 63 && (n >> (e + 1)) != 0) e++;
        m = (e > 31) ? (n >> (e - 31)) : (n << (31 - e));
        res = longint'(e) << FRAC_BITS;
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                res |= 64'd1 << i;
            end
        end
        return res;
    endfunction

    function automatic longint unsigned entropy_of_hist();
        longint unsigned t, lt, q, rsum, lb, h, c, lc, d, qi, ri;
        t = 0; q = 0; rsum = 0;
        foreach (hist[k]) t += hist[k];
        if (t == 0) return 0;
        lt = log2_fix(t);
        foreach (hist[k]) begin
            c = hist[k];
            if (c != 0) begin
                lc = log2_fix(c);
                d = (lt > lc) ? (lt - lc) : 0;
                d &= 64'hFFFF_FFFF;
                qi = 0; ri = 0;
                for (int i = 31; i >= 0; i--) begin
                    qi <<= 1;
                    ri <<= 1;
                    if (d[i]) ri += c;
                    while (ri >= t) begin
                        ri -= t;
                        qi++;
                    end
                end
                q += qi;
                rsum += ri;
                if (rsum >= t) begin
                    rsum -= t;
                    q++;
                end
            end
        end
        lb = (cfg_log_base != 0) ? (longint'(cfg_log_base) << (FRAC_BITS - 8))
                                 : log2_fix(distinct_cnt);
        if (lb == 0) return 0;
        h = (lb == (64'd1 << FRAC_BITS)) ? q : ((q << FRAC_BITS) / lb);
        return (h > 64'hFF_FFFF) ? 64'hFF_FFFF : h;
    endfunction

    function automatic void predict_item(t_in_item it);
        t_out_item r;
        if (it.op == OP_COUNT) begin
            if (cfg_count_np || (it.data_byte >= 8'h20 && it.data_byte <= 8'h7E)) begin
                if (hist[it.data_byte] == 0) distinct_cnt++;
                if (hist[it.data_byte] < 64'hFFFF_FFFF) hist[it.data_byte]++;
                if (byte_cnt != 32'hFFFF_FFFF) byte_cnt++;
            end
        end else begin
            r.entropy_q      = 24'(entropy_of_hist());
            r.distinct_count = distinct_cnt[8:0];
            r.total_count    = byte_cnt;
            expected_results.push_back(r);
            foreach (hist[k]) hist[k] = 0;
            byte_cnt = 0;
            distinct_cnt = 0;
        end
    endfunction

    task automatic send_item(logic op, logic [7:0] b);
        t_in_item it;
        int gap;
        it.op = op;
        it.data_byte = b;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_COUNT_NP) cfg_count_np = val[0];
        else cfg_log_base = val[15:0];
    endtask

    task automatic set_config(bit np, bit [15:0] base);
        wait_drained();
        write_reg(ADDR_COUNT_NP, {31'd0, np});
        write_reg(ADDR_LOG_BASE, {16'd0, base});
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic test_empty_and_single();
        send_item(OP_FINISH, 8'h00);
        send_item(OP_COUNT, 8'h41);
        send_item(OP_COUNT, 8'h41);
        send_item(OP_FINISH, 8'hFF);
    endtask

    task automatic test_printable_edges();
        send_item(OP_COUNT, 8'h1F);
        send_item(OP_COUNT, 8'h20);
        send_item(OP_COUNT, 8'h7E);
        send_item(OP_COUNT, 8'h7F);
        send_item(OP_COUNT, 8'h80);
        send_item(OP_COUNT, 8'hFF);
        send_item(OP_COUNT, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_COUNT, 8'h00);
        send_item(OP_COUNT, 8'h80);
        send_item(OP_FINISH, 8'h00);
    endtask

    task automatic test_nonprintable_all();
        for (int b = 0; b < 256; b++) send_item(OP_COUNT, b[7:0]);
        send_item(OP_FINISH, 8'h00);
    endtask

    task automatic test_random_streams(int n_items);
        int sent;
        int len;
        int alpha;
        int lo;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : $urandom_range(1, 60);
            alpha = $urandom_range(1, 256);
            lo = $urandom_range(0, 256 - alpha);
            for (int i = 0; i < len; i++) begin
                send_item(OP_COUNT, 8'(lo + $urandom_range(0, alpha - 1)));
                sent++;
            end
            send_item(OP_FINISH, 8'($urandom));
            sent++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item %h", o_out_data);
                err_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_data.entropy_q !== exp_r.entropy_q) begin
                    $error("entropy_q exp %0d got %0d", exp_r.entropy_q,
                           o_out_data.entropy_q);
                    err_cnt++;
                end
                if (o_out_data.distinct_count !== exp_r.distinct_count) begin
                    $error("distinct_count exp %0d got %0d", exp_r.distinct_count,
                           o_out_data.distinct_count);
                    err_cnt++;
                end
                if (o_out_data.total_count !== exp_r.total_count) begin
                    $error("total_count exp %0d got %0d", exp_r.total_count,
                           o_out_data.total_count);
                    err_cnt++;
                end
            end
        end
    end

    // output backpressure: a wait drawn per result item
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n || (o_out_valid && i_out_ready)) begin
            draw = out_stall_on ? $urandom_range(0, 19) : 0;
            out_wait    <= draw;
            i_out_ready <= (draw == 0);
        end else if (out_wait != 0) begin
            out_wait    <= out_wait - 1;
            i_out_ready <= (out_wait == 1);
        end
    end

    initial begin
        #50_000_000;
        $display("byte_entropy_meter_tb: FAIL");
        $finish;
    end

    initial begin
        err_cnt = 0;
        out_stall_on = 1'b0;
        out_wait = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        foreach (hist[k]) hist[k] = 0;
        byte_cnt = 0; distinct_cnt = 0; cfg_count_np = 0; cfg_log_base = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_single();
        test_printable_edges();
        set_config(1'b1, 16'h0000);
        test_printable_edges();
        test_nonprintable_all();
        set_config(1'b1, 16'h0100);
        test_nonprintable_all();
        set_config(1'b0, 16'hFFFF);
        test_empty_and_single();
        out_stall_on = 1'b1;
        set_config(1'b1, 16'h0001);
        test_random_streams(300);
        set_config(1'b0, 16'h0000);
        test_random_streams(300);
        set_config(1'b1, 16'h0000);
        test_random_streams(300);
        set_config(1'b1, 16'($urandom_range(1, 65535)));
        test_random_streams(200);
        set_config(1'b1, 16'h0180);
        test_random_streams(200);

        wait_drained();
        if (err_cnt == 0) $display("byte_entropy_meter_tb: PASS");
        else $display("byte_entropy_meter_tb: FAIL");
        $finish;
    end
endmodule
